### sv/dq_pkg.sv
package dq_pkg;

  localparam int unsigned DEPTH_DEF   = 16;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned COUNT_OUT_W = 5;

  localparam logic signed [WORD_W-1:0] EMPTY_WORD = '1;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                     command;
    logic signed [WORD_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] popped_value;
    logic                     popped_valid;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] back_value;
    logic                     is_empty;
    logic [COUNT_OUT_W-1:0]   entry_count;
    logic                     underflow;
    logic                     overflow;
  } out_item_t;

endpackage

### sv/dq_ram.sv
module dq_ram #(
  parameter int unsigned DEPTH = dq_pkg::DEPTH_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [AW-1:0]                     waddr,
  input  logic signed [dq_pkg::WORD_W-1:0]  wdata,
  input  logic [AW-1:0]                     raddr,
  output logic signed [dq_pkg::WORD_W-1:0]  rdata
);
  import dq_pkg::*;

  logic signed [WORD_W-1:0] mem [DEPTH];
  logic signed [WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/double_ended_queue_top.sv
// Bounded deque of signed 32-bit words in a DEPTH-entry ring memory. A command
// is taken at a clock edge where start is high and busy is low; its result is
// on out_data for exactly one cycle, marked by out_valid, in the cycle right
// after the command is taken, and the receiver must take it then. Busy is high
// during the result cycle, so the next command can be taken in the cycle after
// it. This comes from the single read port of the ring memory, whose registered
// data carries the new end word after a pop.
// Pushes on a full deque and pops on an empty one change nothing and are flagged.
module double_ended_queue_top #(
  parameter int unsigned DEPTH = dq_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  dq_pkg::in_item_t  in_data,
  output logic              out_valid,
  output dq_pkg::out_item_t out_data
);
  import dq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } state_t;

  state_t                   state_r, state_nxt;
  logic [AW-1:0]            head_r, head_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic signed [WORD_W-1:0] front_r, front_nxt;
  logic signed [WORD_W-1:0] back_r, back_nxt;
  logic signed [WORD_W-1:0] popped_r, popped_nxt;
  logic                     pvalid_r, pvalid_nxt;
  logic                     under_r, under_nxt;
  logic                     over_r, over_nxt;
  logic                     ld_front_r, ld_front_nxt;
  logic                     ld_back_r, ld_back_nxt;

  logic                     we;
  logic [AW-1:0]            waddr;
  logic [AW-1:0]            raddr;
  logic signed [WORD_W-1:0] rdata;
  logic                     full, empty;
  logic [AW-1:0]            head_dec;
  logic [CW-1:0]            back_off;
  logic signed [WORD_W-1:0] front_word, back_word;

  // head plus offset, wrapped once (sum stays below twice the depth)
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] h,
                                             input logic [CW-1:0] off);
    logic [CW:0] s;
    s = {{(CW + 1 - AW){1'b0}}, h} + {1'b0, off};
    if (s >= (CW + 1)'(DEPTH)) begin
      s = s - (CW + 1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  dq_ram #(.DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_data.push_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign head_dec = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
  assign back_off = (count_r >= CW'(2)) ? count_r - CW'(2) : '0;

  // end words after the command; a pop that leaves at least one word
  // takes the new end word from the memory read
  assign front_word = ld_front_r ? rdata : front_r;
  assign back_word  = ld_back_r ? rdata : back_r;

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    front_nxt    = front_r;
    back_nxt     = back_r;
    popped_nxt   = popped_r;
    pvalid_nxt   = pvalid_r;
    under_nxt    = under_r;
    over_nxt     = over_r;
    ld_front_nxt = ld_front_r;
    ld_back_nxt  = ld_back_r;
    we           = 1'b0;
    waddr        = ring_add(head_r, count_r[CW-1:0]);
    raddr        = ring_add(head_r, CW'(1));

    unique case (state_r)
      ST_IDLE: begin
        if (in_data.command == CMD_POP_BACK) begin
          raddr = ring_add(head_r, back_off);
        end
        if (start) begin
          state_nxt    = ST_RESP;
          popped_nxt   = '0;
          pvalid_nxt   = 1'b0;
          under_nxt    = 1'b0;
          over_nxt     = 1'b0;
          ld_front_nxt = 1'b0;
          ld_back_nxt  = 1'b0;
          unique case (in_data.command)
            CMD_PUSH_FRONT: begin
              if (full) begin
                over_nxt = 1'b1;
              end else begin
                we        = 1'b1;
                waddr     = head_dec;
                head_nxt  = head_dec;
                count_nxt = count_r + CW'(1);
                front_nxt = in_data.push_value;
                if (empty) begin
                  back_nxt = in_data.push_value;
                end
              end
            end
            CMD_PUSH_BACK: begin
              if (full) begin
                over_nxt = 1'b1;
              end else begin
                we        = 1'b1;
                count_nxt = count_r + CW'(1);
                back_nxt  = in_data.push_value;
                if (empty) begin
                  front_nxt = in_data.push_value;
                end
              end
            end
            CMD_POP_FRONT: begin
              if (empty) begin
                under_nxt = 1'b1;
              end else begin
                popped_nxt   = front_r;
                pvalid_nxt   = 1'b1;
                head_nxt     = ring_add(head_r, CW'(1));
                count_nxt    = count_r - CW'(1);
                ld_front_nxt = (count_r > CW'(1));
              end
            end
            CMD_POP_BACK: begin
              if (empty) begin
                under_nxt = 1'b1;
              end else begin
                popped_nxt  = back_r;
                pvalid_nxt  = 1'b1;
                count_nxt   = count_r - CW'(1);
                ld_back_nxt = (count_r > CW'(1));
              end
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end
      ST_RESP: begin
        state_nxt    = ST_IDLE;
        front_nxt    = front_word;
        back_nxt     = back_word;
        ld_front_nxt = 1'b0;
        ld_back_nxt  = 1'b0;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      head_r     <= '0;
      count_r    <= '0;
      pvalid_r   <= 1'b0;
      under_r    <= 1'b0;
      over_r     <= 1'b0;
      ld_front_r <= 1'b0;
      ld_back_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      count_r    <= count_nxt;
      pvalid_r   <= pvalid_nxt;
      under_r    <= under_nxt;
      over_r     <= over_nxt;
      ld_front_r <= ld_front_nxt;
      ld_back_r  <= ld_back_nxt;
    end
    front_r  <= front_nxt;
    back_r   <= back_nxt;
    popped_r <= popped_nxt;
  end

  assign busy      = (state_r == ST_RESP);
  assign out_valid = (state_r == ST_RESP);

  always_comb begin
    out_data.popped_value = popped_r;
    out_data.popped_valid = pvalid_r;
    out_data.front_value  = empty ? EMPTY_WORD : front_word;
    out_data.back_value   = empty ? EMPTY_WORD : back_word;
    out_data.is_empty     = empty;
    out_data.entry_count  = COUNT_OUT_W'(count_r);
    out_data.underflow    = under_r;
    out_data.overflow     = over_r;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("stored count above depth");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= AW'(DEPTH - 1))
    else $error("head index out of ring");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_valid)
    else $error("command taken without a result in the next cycle");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(pvalid_r && (under_r || over_r)) && !(under_r && over_r))
    else $error("conflicting result flags");

  a_pop_loads_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (ld_front_r || ld_back_r) |-> !empty && pvalid_r)
    else $error("memory end word loaded without a pop");

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps

class deque_scoreboard;
  localparam int unsigned DEPTH = dq_pkg::DEPTH_DEF;

  logic signed [dq_pkg::WORD_W-1:0] words [DEPTH];
  int unsigned head;
  int unsigned fill;
  dq_pkg::out_item_t expected_results [$];
  int unsigned mismatches;
  int unsigned checked;
  int unsigned overflows;
  int unsigned underflows;
  int unsigned full_hits;

  function new();
    head = 0;
    fill = 0;
    mismatches = 0;
    checked = 0;
    overflows = 0;
    underflows = 0;
    full_hits = 0;
  endfunction

  // works out the result of one accepted item and advances the deque copy
  function void note_command(dq_pkg::in_item_t item);
    dq_pkg::out_item_t r;
    int unsigned pos;
    r = '0;
    case (item.command)
      dq_pkg::CMD_PUSH_FRONT: begin
        if (fill >= DEPTH) begin
          r.overflow = 1'b1;
        end else begin
          head = (head + DEPTH - 1) % DEPTH;
          words[head] = item.push_value;
          fill++;
        end
      end
      dq_pkg::CMD_PUSH_BACK: begin
        if (fill >= DEPTH) begin
          r.overflow = 1'b1;
        end else begin
          words[(head + fill) % DEPTH] = item.push_value;
          fill++;
        end
      end
      dq_pkg::CMD_POP_FRONT: begin
        if (fill == 0) begin
          r.underflow = 1'b1;
        end else begin
          r.popped_value = words[head];
          r.popped_valid = 1'b1;
          head = (head + 1) % DEPTH;
          fill--;
        end
      end
      default: begin
        if (fill == 0) begin
          r.underflow = 1'b1;
        end else begin
          pos = (head + fill - 1) % DEPTH;
          r.popped_value = words[pos];
          r.popped_valid = 1'b1;
          fill--;
        end
      end
    endcase
    if (fill == 0) begin
      r.front_value = dq_pkg::EMPTY_WORD;
      r.back_value  = dq_pkg::EMPTY_WORD;
      r.is_empty    = 1'b1;
    end else begin
      r.front_value = words[head];
      r.back_value  = words[(head + fill - 1) % DEPTH];
      r.is_empty    = 1'b0;
    end
    r.entry_count = fill[dq_pkg::COUNT_OUT_W-1:0];
    if (r.overflow) overflows++;
    if (r.underflow) underflows++;
    if (fill == DEPTH) full_hits++;
    expected_results.insert(expected_results.size(), r);
  endfunction

  function void report_mismatch(string what, dq_pkg::out_item_t exp_r, dq_pkg::out_item_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s) at %0t", what, $realtime);
      $display("  expected pop=%h/%b front=%h back=%h empty=%b count=%0d uf=%b of=%b",
               exp_r.popped_value, exp_r.popped_valid, exp_r.front_value,
               exp_r.back_value, exp_r.is_empty, exp_r.entry_count,
               exp_r.underflow, exp_r.overflow);
      $display("  actual   pop=%h/%b front=%h back=%h empty=%b count=%0d uf=%b of=%b",
               got.popped_value, got.popped_valid, got.front_value,
               got.back_value, got.is_empty, got.entry_count,
               got.underflow, got.overflow);
    end
  endfunction

  function void check_result(dq_pkg::out_item_t got);
    dq_pkg::out_item_t exp_r;
    if (expected_results.size() == 0) begin
      exp_r = '0;
      report_mismatch("result with no item pending", exp_r, got);
      return;
    end
    exp_r = expected_results[0];
    expected_results.delete(0);
    checked++;
    if (got.popped_value !== exp_r.popped_value ||
        got.popped_valid !== exp_r.popped_valid ||
        got.front_value  !== exp_r.front_value  ||
        got.back_value   !== exp_r.back_value   ||
        got.is_empty     !== exp_r.is_empty     ||
        got.entry_count  !== exp_r.entry_count  ||
        got.underflow    !== exp_r.underflow    ||
        got.overflow     !== exp_r.overflow) begin
      report_mismatch("field", exp_r, got);
    end
  endfunction

  function int unsigned pending();
    return expected_results.size();
  endfunction
endclass

module testbench;
  import dq_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_data = '0;
  logic out_valid;
  out_item_t out_data;

  deque_scoreboard board = new();
  int unsigned sent_items = 0;
  bit allow_idle = 1'b1;

  always #5 clk = ~clk;

  double_ended_queue_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) board.note_command(in_data);
      if (out_valid) board.check_result(out_data);
    end
  end

  // hold start until the block takes the item, idle now and then first
  task automatic send_command(cmd_t cmd, logic signed [WORD_W-1:0] value);
    in_item_t item;
    item.command    = cmd;
    item.push_value = value;
    if (allow_idle && $urandom_range(0, 99) < 16) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_items++;
  endtask

  task automatic drain_results();
    int unsigned waited;
    waited = 0;
    start <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
  endtask

  function automatic logic signed [WORD_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic cmd_t pick_command(int unsigned push_bias);
    if ($urandom_range(0, 99) < push_bias)
      return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    return $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
  endfunction

  initial begin
    int unsigned bias;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty pops, signed extremes at both ends, then back to empty
    send_command(CMD_POP_FRONT, 32'sh1234_5678);
    send_command(CMD_POP_BACK, 32'sh0);
    send_command(CMD_PUSH_FRONT, 32'sh7fff_ffff);
    send_command(CMD_PUSH_BACK, 32'sh8000_0000);
    send_command(CMD_PUSH_FRONT, -32'sd1);
    send_command(CMD_PUSH_BACK, 32'sh0);
    send_command(CMD_POP_FRONT, 32'sh5555_5555);
    send_command(CMD_POP_BACK, 32'shaaaa_aaaa);
    send_command(CMD_POP_BACK, 32'sh0);
    send_command(CMD_POP_FRONT, 32'sh0);
    send_command(CMD_POP_FRONT, 32'sh0);
    send_command(CMD_PUSH_BACK, 32'sh0000_0001);
    send_command(CMD_POP_FRONT, 32'sh0);
    drain_results();

    // phases cycle through push-heavy, balanced and pop-heavy mixes, to fill past full and drain past empty
    for (int phase = 0; phase < 15; phase++) begin
      allow_idle = !(phase >= 4 && phase <= 6);
      case (phase % 3)
        0: bias = 80;
        1: bias = 50;
        default: bias = 20;
      endcase
      for (int n = 0; n < 50; n++) begin
        send_command(pick_command(bias), pick_value());
      end
      if (phase % 4 == 1) drain_results();
    end

    drain_results();
    repeat (5) @(posedge clk);
    if (board.pending() != 0) board.mismatches++;
    $display("sent %0d items, checked %0d results", sent_items, board.checked);
    $display("overflows %0d, underflows %0d, full after push %0d times",
             board.overflows, board.underflows, board.full_hits);
    if (board.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule

### filelist.f
sv/dq_pkg.sv
sv/dq_ram.sv
sv/double_ended_queue_top.sv
dv/testbench.sv
